@@ src/lpfr_pkg.sv @@
package lpfr_pkg;

	// Header length field size in bytes (1 to 4) and hard payload ceiling
	localparam int unsigned LENGTH_FIELD_BYTES = 4;
	localparam logic [7:0] PAYLOAD_LIMIT = 8'd255;

	// Last header byte index
	localparam logic [1:0] HDR_LAST_IDX = 2'(LENGTH_FIELD_BYTES - 1);

	// Register reset values
	localparam logic [7:0] MAX_LENGTH_RST = 8'd255;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

	// Register index, taken from paddr[2]
	localparam logic REG_MAX_LENGTH = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;

	// Input request kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HEADER = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_BYTE = 2'd0,
		EV_EMPTY = 2'd1,
		EV_TOO_LONG = 2'd2,
		EV_TIMEOUT = 2'd3
	} event_t;

	typedef struct packed {
		logic [7:0] max_length;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic vld;
		event_t ev;
		logic [7:0] pbyte;
		logic last;
		logic [7:0] flen;
	} res_t;

endpackage

@@ src/lpfr_cfg.sv @@
module lpfr_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output lpfr_pkg::cfg_t cfg
);

	logic [7:0] max_length_q;
	logic [15:0] timeout_ticks_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= lpfr_pkg::MAX_LENGTH_RST;
			timeout_ticks_q <= lpfr_pkg::TIMEOUT_TICKS_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				lpfr_pkg::REG_MAX_LENGTH: max_length_q <= pwdata[7:0];
				lpfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[2])
			lpfr_pkg::REG_MAX_LENGTH: prdata = {24'd0, max_length_q};
			lpfr_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_q};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg.max_length = max_length_q;
	assign cfg.timeout_ticks = timeout_ticks_q;

endmodule

@@ src/lpfr_core.sv @@
module lpfr_core (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input logic opcode,
	input logic [7:0] rx_byte,
	input lpfr_pkg::cfg_t cfg,
	output lpfr_pkg::res_t res
);

	lpfr_pkg::phase_t phase_q, phase_d, ph_cur;
	logic [1:0] hdr_idx_q, hdr_idx_d, hdr_idx_cur;
	logic [7:0] len_lo_q, len_lo_d, len_lo_new;
	logic hi_nz_q, hi_nz_d, hi_nz_new;
	logic [7:0] rem_q, rem_d;
	logic [15:0] tick_cnt_q, tick_cnt_d, cnt_inc;
	logic [7:0] limit;
	logic is_tick, tmo, hdr_done, too_long, is_empty, is_final;

	// Shared decode of the current request against the state
	always_comb begin
		case (phase_q)
			lpfr_pkg::PH_HEADER: ph_cur = lpfr_pkg::PH_HEADER;
			lpfr_pkg::PH_PAYLOAD: ph_cur = lpfr_pkg::PH_PAYLOAD;
			default: ph_cur = lpfr_pkg::PH_IDLE;
		endcase
		is_tick = (opcode == lpfr_pkg::OP_TICK);
		cnt_inc = tick_cnt_q + 16'd1;
		tmo = (cnt_inc >= cfg.timeout_ticks);
		hdr_idx_cur = (ph_cur == lpfr_pkg::PH_IDLE) ? 2'd0 : hdr_idx_q;
		hdr_done = (hdr_idx_cur == lpfr_pkg::HDR_LAST_IDX);
		// Only the low byte is kept; upper bytes just flag nonzero
		len_lo_new = (hdr_idx_cur == 2'd0) ? rx_byte : len_lo_q;
		hi_nz_new = ((ph_cur == lpfr_pkg::PH_IDLE) ? 1'b0 : hi_nz_q)
			| ((hdr_idx_cur != 2'd0) && (rx_byte != 8'd0));
		limit = (cfg.max_length < lpfr_pkg::PAYLOAD_LIMIT) ? cfg.max_length
			: lpfr_pkg::PAYLOAD_LIMIT;
		too_long = hi_nz_new || (len_lo_new > limit);
		is_empty = !hi_nz_new && (len_lo_new == 8'd0);
		is_final = (rem_q <= 8'd1);
	end

	// Next phase
	always_comb begin
		phase_d = ph_cur;
		unique case (ph_cur)
			lpfr_pkg::PH_IDLE, lpfr_pkg::PH_HEADER: begin
				if (is_tick) begin
					if (ph_cur == lpfr_pkg::PH_HEADER && tmo)
						phase_d = lpfr_pkg::PH_IDLE;
				end else if (hdr_done) begin
					phase_d = (too_long || is_empty) ? lpfr_pkg::PH_IDLE
						: lpfr_pkg::PH_PAYLOAD;
				end else begin
					phase_d = lpfr_pkg::PH_HEADER;
				end
			end
			lpfr_pkg::PH_PAYLOAD: begin
				if (is_tick ? tmo : is_final)
					phase_d = lpfr_pkg::PH_IDLE;
			end
			default: phase_d = lpfr_pkg::PH_IDLE;
		endcase
	end

	// Counters, length tracking and result
	always_comb begin
		hdr_idx_d = 2'd0;
		len_lo_d = 8'd0;
		hi_nz_d = 1'b0;
		rem_d = 8'd0;
		tick_cnt_d = 16'd0;
		res = '0;
		unique case (ph_cur)
			lpfr_pkg::PH_IDLE, lpfr_pkg::PH_HEADER: begin
				if (is_tick) begin
					if (ph_cur == lpfr_pkg::PH_HEADER) begin
						if (tmo) begin
							res.vld = 1'b1;
							res.ev = lpfr_pkg::EV_TIMEOUT;
						end else begin
							hdr_idx_d = hdr_idx_q;
							len_lo_d = len_lo_q;
							hi_nz_d = hi_nz_q;
							tick_cnt_d = cnt_inc;
						end
					end
				end else if (!hdr_done) begin
					hdr_idx_d = hdr_idx_cur + 2'd1;
					len_lo_d = len_lo_new;
					hi_nz_d = hi_nz_new;
				end else if (too_long) begin
					res.vld = 1'b1;
					res.ev = lpfr_pkg::EV_TOO_LONG;
					res.flen = hi_nz_new ? 8'd255 : len_lo_new;
				end else if (is_empty) begin
					res.vld = 1'b1;
					res.ev = lpfr_pkg::EV_EMPTY;
				end else begin
					len_lo_d = len_lo_new;
					rem_d = len_lo_new;
				end
			end
			lpfr_pkg::PH_PAYLOAD: begin
				if (is_tick) begin
					if (tmo) begin
						res.vld = 1'b1;
						res.ev = lpfr_pkg::EV_TIMEOUT;
						res.flen = len_lo_q;
					end else begin
						len_lo_d = len_lo_q;
						rem_d = rem_q;
						tick_cnt_d = cnt_inc;
					end
				end else begin
					res.vld = 1'b1;
					res.ev = lpfr_pkg::EV_BYTE;
					res.pbyte = rx_byte;
					res.last = is_final;
					res.flen = len_lo_q;
					if (!is_final) begin
						len_lo_d = len_lo_q;
						rem_d = rem_q - 8'd1;
					end
				end
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpfr_pkg::PH_IDLE;
			hdr_idx_q <= 2'd0;
			len_lo_q <= 8'd0;
			hi_nz_q <= 1'b0;
			rem_q <= 8'd0;
			tick_cnt_q <= 16'd0;
		end else if (step_en) begin
			phase_q <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			len_lo_q <= len_lo_d;
			hi_nz_q <= hi_nz_d;
			rem_q <= rem_d;
			tick_cnt_q <= tick_cnt_d;
		end
	end

	// Header index stays inside the length field
	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lpfr_pkg::PH_HEADER |-> hdr_idx_q <= lpfr_pkg::HDR_LAST_IDX)
		else $error("header index past length field");

	// An open payload always has bytes left
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lpfr_pkg::PH_PAYLOAD |-> rem_q != 8'd0)
		else $error("payload phase with zero bytes remaining");

	// Idle leaves every counter cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lpfr_pkg::PH_IDLE |-> (tick_cnt_q == 16'd0 && hdr_idx_q == 2'd0
		&& rem_q == 8'd0))
		else $error("idle with stale counters");

	// A byte request always clears the tick counter
	a_byte_clr: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && opcode == lpfr_pkg::OP_BYTE |=> tick_cnt_q == 16'd0)
		else $error("tick counter not cleared by byte");

endmodule

@@ src/length_prefixed_frame_receiver_unit.sv @@
// Length-prefixed frame receiver.
// A request accepted into the input register is processed by the core; the result
// is registered and shown on m_tvalid. Throughput: one request per cycle while no
// result waits on a stalled output; a single-stage update loop sets the rate.
// Reset (arst_n low) empties both stages, returns to idle and reloads registers.
module length_prefixed_frame_receiver_unit (
	input logic clk,
	input logic arst_n,
	// APB configuration
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// Input stream
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] rx_byte
	input logic [0:0] s_tuser, // [0] opcode
	// Output stream
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata, // [7:0] payload_byte, [15:8] frame_length
	output logic [1:0] m_tuser, // [1:0] event_res
	output logic m_tlast
);

	lpfr_pkg::cfg_t cfg;
	lpfr_pkg::res_t res;

	logic s1_vld_q;
	logic op_s1;
	logic [7:0] byte_s1;
	logic out_vld_q;
	logic [15:0] out_data_q;
	logic [1:0] out_user_q;
	logic out_last_q;
	logic out_ok, s1_fire, s_fire;

	lpfr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	lpfr_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(s1_fire),
		.opcode(op_s1),
		.rx_byte(byte_s1),
		.cfg(cfg),
		.res(res)
	);

	// Handshake: a request without result never waits on the output
	assign out_ok = !out_vld_q || m_tready;
	assign s1_fire = s1_vld_q && (!res.vld || out_ok);
	assign s_tready = !s1_vld_q || s1_fire;
	assign s_fire = s_tvalid && s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_vld_q <= 1'b0;
		else if (s_tready)
			s1_vld_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_ok)
			out_vld_q <= s1_fire && res.vld;
	end

	always_ff @(posedge clk) begin
		if (out_ok && s1_fire && res.vld) begin
			out_data_q <= {res.flen, res.pbyte};
			out_user_q <= res.ev;
			out_last_q <= res.last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;
	assign m_tlast = out_last_q;

endmodule

@@ test/length_prefixed_frame_receiver_unit_tb.sv @@
module length_prefixed_frame_receiver_unit_tb;

	// One report from the receiver
	typedef struct packed {
		lpfr_pkg::event_t ev;
		logic [7:0] pbyte;
		logic last;
		logic [7:0] flen;
	} frame_report_t;

	// Frame decoder mirror plus the queue of reports it still owes
	class frame_scoreboard;
		logic [7:0] max_len;
		logic [15:0] tmo;
		lpfr_pkg::phase_t ph;
		logic [1:0] hidx;
		logic [31:0] acc;
		logic [7:0] remaining;
		logic [15:0] ticks;
		frame_report_t owed[$];
		int errors;

		function new();
			max_len = lpfr_pkg::MAX_LENGTH_RST;
			tmo = lpfr_pkg::TIMEOUT_TICKS_RST;
			errors = 0;
			return_to_idle();
		endfunction

		function void return_to_idle();
			ph = lpfr_pkg::PH_IDLE;
			hidx = '0;
			acc = '0;
			remaining = '0;
			ticks = '0;
		endfunction

		function void set_register(input logic idx, input logic [31:0] value);
			if (idx == lpfr_pkg::REG_MAX_LENGTH) begin
				max_len = value[7:0];
			end else begin
				tmo = value[15:0];
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void owe(input lpfr_pkg::event_t ev, input logic [7:0] pbyte,
				input logic last, input logic [7:0] flen);
			frame_report_t rep;
			rep.ev = ev;
			rep.pbyte = pbyte;
			rep.last = last;
			rep.flen = flen;
			owed.push_back(rep);
		endfunction

		// Advance the mirror by one accepted request
		function void accept_request(input logic op, input logic [7:0] b);
			logic [7:0] limit;
			logic fin;
			limit = (max_len < lpfr_pkg::PAYLOAD_LIMIT) ? max_len
				: lpfr_pkg::PAYLOAD_LIMIT;
			if (op == lpfr_pkg::OP_TICK) begin
				if (ph == lpfr_pkg::PH_IDLE) return;
				ticks = ticks + 16'd1;
				if (ticks < tmo) return;
				owe(lpfr_pkg::EV_TIMEOUT, 8'd0, 1'b0,
					(ph == lpfr_pkg::PH_PAYLOAD) ? acc[7:0] : 8'd0);
				return_to_idle();
				return;
			end
			ticks = '0;
			// payload byte
			if (ph == lpfr_pkg::PH_PAYLOAD) begin
				fin = (remaining <= 8'd1);
				owe(lpfr_pkg::EV_BYTE, b, fin, acc[7:0]);
				if (fin) begin
					return_to_idle();
				end else begin
					remaining = remaining - 8'd1;
				end
				return;
			end
			// header byte, little-endian
			if (ph == lpfr_pkg::PH_IDLE) begin
				ph = lpfr_pkg::PH_HEADER;
				hidx = '0;
				acc = '0;
			end
			acc = acc | (32'(b) << (8 * hidx));
			if (int'(hidx) + 1 < lpfr_pkg::LENGTH_FIELD_BYTES) begin
				hidx = hidx + 2'd1;
				return;
			end
			if (acc > 32'(limit)) begin
				owe(lpfr_pkg::EV_TOO_LONG, 8'd0, 1'b0,
					(acc > 32'd255) ? 8'd255 : acc[7:0]);
				return_to_idle();
			end else if (acc == 32'd0) begin
				owe(lpfr_pkg::EV_EMPTY, 8'd0, 1'b0, 8'd0);
				return_to_idle();
			end else begin
				ph = lpfr_pkg::PH_PAYLOAD;
				hidx = '0;
				remaining = acc[7:0];
			end
		endfunction

		// Compare a delivered report with the oldest owed one
		function void check_report(input lpfr_pkg::event_t ev, input logic [7:0] pbyte,
				input logic last, input logic [7:0] flen);
			frame_report_t exp_rep;
			if (owed.size() == 0) begin
				$display("%0t: unexpected report ev=%0d byte=%02h last=%0b len=%0d",
					$time, ev, pbyte, last, flen);
				errors++;
				return;
			end
			exp_rep = owed.pop_front();
			if (ev !== exp_rep.ev) begin
				$display("%0t: event expected %0d actual %0d", $time, exp_rep.ev, ev);
				errors++;
			end
			if (pbyte !== exp_rep.pbyte) begin
				$display("%0t: payload_byte expected %02h actual %02h",
					$time, exp_rep.pbyte, pbyte);
				errors++;
			end
			if (last !== exp_rep.last) begin
				$display("%0t: last expected %0b actual %0b", $time, exp_rep.last, last);
				errors++;
			end
			if (flen !== exp_rep.flen) begin
				$display("%0t: frame_length expected %0d actual %0d",
					$time, exp_rep.flen, flen);
				errors++;
			end
		endfunction

		// Anything still owed at the end is a miss
		function int close_out();
			foreach (owed[i]) begin
				$display("%0t: missing report ev=%0d byte=%02h last=%0b len=%0d %s",
					$time, owed[i].ev, owed[i].pbyte, owed[i].last, owed[i].flen,
					"expected, none seen");
				errors++;
			end
			return errors;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata; // [7:0] rx_byte
	logic [0:0] s_tuser; // [0] opcode
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata; // [7:0] payload_byte, [15:8] frame_length
	logic [1:0] m_tuser; // [1:0] event_res
	logic m_tlast;

	frame_scoreboard sb = new();
	logic no_idle = 1'b0;
	logic hold_off_req = 1'b0;
	int items_sent = 0;

	length_prefixed_frame_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Mostly no gap, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Offer one request and wait until it is taken
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tuser = op;
		do @(posedge clk); while (!s_tready);
		sb.accept_request(op, b);
		items_sent++;
	endtask

	task automatic send_header(input logic [31:0] len);
		for (int i = 0; i < lpfr_pkg::LENGTH_FIELD_BYTES; i++) begin
			spacing_ticks();
			send_item(lpfr_pkg::OP_BYTE, len[8*i +: 8]);
		end
	endtask

	// Ticks between bytes: usually none, some below the timeout, rarely enough to abort
	task automatic spacing_ticks();
		int r;
		int n;
		r = $urandom_range(99);
		n = 0;
		if (r < 3 && sb.tmo <= 16'd8) begin
			n = int'(sb.tmo);
		end else if (r < 20 && sb.tmo > 16'd1) begin
			n = $urandom_range((int'(sb.tmo) - 1 < 4) ? int'(sb.tmo) - 1 : 4, 1);
		end
		repeat (n) send_item(lpfr_pkg::OP_TICK, 8'($urandom));
	endtask

	// Stop sending and let every owed report come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(input logic [7:0] max_len, input logic [15:0] tmo);
		wait_drained();
		write_register(lpfr_pkg::REG_MAX_LENGTH, 32'(max_len));
		write_register(lpfr_pkg::REG_TIMEOUT_TICKS, 32'(tmo));
	endtask

	// One random unit: mostly a framed request sequence, else tick bursts or stray bytes
	task automatic random_unit();
		int sel;
		int r;
		int lim;
		int body;
		logic [31:0] len;
		lim = (sb.max_len < lpfr_pkg::PAYLOAD_LIMIT) ? int'(sb.max_len)
			: int'(lpfr_pkg::PAYLOAD_LIMIT);
		sel = $urandom_range(99);
		if (sel < 75) begin
			r = $urandom_range(99);
			if (r < 65) len = $urandom_range((lim < 12) ? lim : 12);
			else if (r < 69) len = lim;
			else if (r < 77) len = 0;
			else if (r < 87) len = lim + 1;
			else if (r < 95) len = $urandom;
			else len = $urandom_range(lim);
			send_header(len);
			if (len != 0 && len <= lim) begin
				body = int'(len);
				// occasionally cut the frame short
				if ($urandom_range(9) == 0) body = $urandom_range(int'(len) - 1);
				repeat (body) begin
					spacing_ticks();
					send_item(lpfr_pkg::OP_BYTE, 8'($urandom));
				end
			end
		end else if (sel < 88) begin
			r = (sb.tmo <= 16'd20) ? $urandom_range(int'(sb.tmo) + 1, 1) : $urandom_range(5, 1);
			repeat (r) send_item(lpfr_pkg::OP_TICK, 8'($urandom));
		end else begin
			send_item(lpfr_pkg::OP_BYTE, 8'($urandom));
		end
	endtask

	task automatic random_run(input int budget);
		int start;
		start = items_sent;
		while (items_sent - start < budget) random_unit();
	endtask

	// Result side: random back-pressure, one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = 300;
			end else if (stall == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_report(lpfr_pkg::event_t'(m_tuser), m_tdata[7:0], m_tlast,
					m_tdata[15:8]);
			end
		end
	end

	// Watchdog
	initial begin
		#1600000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lpfr_pkg::OP_BYTE;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: idle tick, empty frame, oversize lengths, two-byte frame
		send_item(lpfr_pkg::OP_TICK, 8'hFF);
		send_header(32'd0);
		send_header(32'hFFFF_FFFF);
		send_header(32'h0000_0100);
		send_header(32'd2);
		send_item(lpfr_pkg::OP_BYTE, 8'h00);
		send_item(lpfr_pkg::OP_BYTE, 8'hFF);

		// Single-tick timeout, in the header and in the payload
		configure(8'd255, 16'd1);
		send_item(lpfr_pkg::OP_BYTE, 8'h5A);
		send_item(lpfr_pkg::OP_TICK, 8'h00);
		send_header(32'd3);
		send_item(lpfr_pkg::OP_BYTE, 8'hA5);
		send_item(lpfr_pkg::OP_TICK, 8'h00);
		random_run(100);

		// Zero limit and zero timeout
		configure(8'd0, 16'd0);
		random_run(100);

		// Back-to-back traffic with no idling
		configure(8'($urandom_range(254, 1)), 16'($urandom_range(8, 2)));
		no_idle = 1'b1;
		random_run(150);
		no_idle = 1'b0;

		// Largest settings, with the result side held off for a long stretch
		configure(8'd255, 16'd65535);
		hold_off_req = 1'b1;
		random_run(150);

		configure(8'($urandom_range(255)), 16'($urandom_range(20, 1)));
		random_run(150);

		configure(8'($urandom), 16'($urandom_range(65535, 1)));
		random_run(100);

		configure(8'd1, 16'd2);
		random_run(100);

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.close_out() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/lpfr_pkg.sv
src/lpfr_cfg.sv
src/lpfr_core.sv
src/length_prefixed_frame_receiver_unit.sv
test/length_prefixed_frame_receiver_unit_tb.sv
